// File: hdl/pfrc_pkg.sv
// Shared constants and types for the packed-float / RGBE pixel converter.
package pfrc_pkg;

  localparam int          E_BIAS      = 127 - 15;
  localparam logic [31:0] NO_EXP_WORD = 32'h7180_8080;
  localparam logic [9:0]  MAN_MASK    = 10'h3FF;
  localparam logic [10:0] HIDDEN_BIT  = 11'h400;
  localparam logic [4:0]  EXP_MAX     = 5'd30;
  localparam logic [4:0]  EXP_INF     = 5'd31;

  localparam logic DIR_TO_RGBE   = 1'b0;
  localparam logic DIR_TO_PACKED = 1'b1;

  typedef struct packed {
    logic        dir;
    logic [31:0] pixel;
  } pfrc_item_t;

endpackage

// File: hdl/pfrc_to_rgbe.sv
// Packed R11G11B10 float word to shared-exponent RGBE word, combinational.
module pfrc_to_rgbe (
  input  logic [31:0] pixel,
  output logic [31:0] rgbe
);
  import pfrc_pkg::*;

  function automatic logic [4:0] usable_exp(input logic [4:0] e);
    return (e != EXP_INF) ? e : 5'd0;
  endfunction

  function automatic logic [7:0] chan_byte(input logic [4:0] e, input logic [9:0] m,
                                           input logic [4:0] em);
    logic [5:0]  lim;
    logic [5:0]  sh;
    logic [10:0] shifted;
    lim     = {1'b0, em} + 6'd3;
    sh      = (lim >= {1'b0, e}) ? (lim - {1'b0, e}) : 6'd0;
    shifted = (HIDDEN_BIT | {1'b0, m}) >> sh;
    return (sh >= 6'd11) ? 8'd0 : shifted[7:0];
  endfunction

  logic [4:0] exp_r, exp_g, exp_b;
  logic [9:0] man_r, man_g, man_b;
  logic [4:0] use_r, use_g, use_b;
  logic [4:0] max_rg, exp_shared;
  logic [7:0] exp_byte;

  // Widen each field: exponent on top, low mantissa bits refilled from the field top.
  assign exp_r = pixel[10:6];
  assign man_r = {pixel[5:0], pixel[10:7]};
  assign exp_g = pixel[21:17];
  assign man_g = {pixel[16:11], pixel[21:18]};
  assign exp_b = pixel[31:27];
  assign man_b = {pixel[26:22], pixel[31:27]};

  assign use_r      = usable_exp(exp_r);
  assign use_g      = usable_exp(exp_g);
  assign use_b      = usable_exp(exp_b);
  assign max_rg     = (use_g > use_r) ? use_g : use_r;
  assign exp_shared = (use_b > max_rg) ? use_b : max_rg;
  assign exp_byte   = {3'd0, exp_shared} + 8'(E_BIAS);

  always_comb begin
    if (exp_shared == 5'd0) begin
      rgbe = NO_EXP_WORD;
    end else begin
      rgbe = {exp_byte,
              chan_byte(exp_b, man_b, exp_shared),
              chan_byte(exp_g, man_g, exp_shared),
              chan_byte(exp_r, man_r, exp_shared)};
    end
  end

endmodule

// File: hdl/pfrc_to_packed.sv
// RGBE word to packed R11G11B10 float word, combinational.
module pfrc_to_packed (
  input  logic [31:0] rgbe,
  output logic [31:0] pixel
);
  import pfrc_pkg::*;

  function automatic logic [2:0] lzc8(input logic [7:0] b);
    logic [2:0] cnt;
    logic       found;
    cnt   = 3'd0;
    found = 1'b0;
    for (int i = 7; i >= 0; i--) begin
      if (!found && b[i]) begin
        found = 1'b1;
        cnt   = 3'(7 - i);
      end
    end
    return cnt;
  endfunction

  // Returns exponent (14:10) and mantissa (9:0) of one channel.
  function automatic logic [14:0] chan15(input logic [7:0] b, input logic [7:0] eb);
    logic [2:0]        lz;
    logic [7:0]        bn;
    logic signed [9:0] e;
    lz = lzc8(b);
    bn = b << lz;
    e  = signed'({2'b00, eb}) - signed'(10'(E_BIAS)) - signed'({7'd0, lz});
    if (b == 8'd0 || e < 10'sd1) begin
      return 15'd0;
    end else if (e > signed'({5'd0, EXP_MAX})) begin
      return {EXP_MAX, MAN_MASK};
    end else begin
      return {e[4:0], bn[6:0], 3'b000};
    end
  endfunction

  logic [14:0] ch_r, ch_g, ch_b;

  assign ch_r = chan15(rgbe[7:0],   rgbe[31:24]);
  assign ch_g = chan15(rgbe[15:8],  rgbe[31:24]);
  assign ch_b = chan15(rgbe[23:16], rgbe[31:24]);

  // Truncate into the packed fields.
  assign pixel = {ch_b[14:5], ch_g[14:4], ch_r[14:4]};

endmodule

// File: hdl/packed_float_rgbe_convert.sv
// Top level of the packed-float / RGBE pixel converter with handshake and config.
// Each accepted pixel passes through the input register and then the result register.
// Throughput: one pixel per cycle unless out_ready stalls; both conversions are single-pass
//   logic between the input and result registers, and ready propagates back through both.
// Reset (rst, synchronous, active high): empties both stages and sets direction to 0.
// Configuration is always ready; direction rides along with each captured pixel.
module packed_float_rgbe_convert (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        direction,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] pixel_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] pixel_out
);
  import pfrc_pkg::*;

  logic                 dir_mode;
  logic                 s1_valid;
  pfrc_pkg::pfrc_item_t s1_item;
  logic                 s1_advance;
  logic                 out_advance;
  logic [31:0]          rgbe_word;
  logic [31:0]          packed_word;
  logic [31:0]          result_next;

  // Config writes are accepted in any cycle; only bit 0 matters.
  assign cfg_ready = 1'b1;

  // Advance the result register when it is empty or being drained this cycle;
  // advance the input register when it is empty or moving into the result register.
  assign out_advance = !out_valid || out_ready;
  assign s1_advance  = !s1_valid || out_advance;
  assign in_ready    = s1_advance;

  pfrc_to_rgbe u_to_rgbe (
    .pixel (s1_item.pixel),
    .rgbe  (rgbe_word)
  );

  pfrc_to_packed u_to_packed (
    .rgbe  (s1_item.pixel),
    .pixel (packed_word)
  );

  // Pick the conversion the item was captured with.
  assign result_next = (s1_item.dir == DIR_TO_PACKED) ? packed_word : rgbe_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      dir_mode  <= DIR_TO_RGBE;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        dir_mode <= direction;
      end
      if (s1_advance) begin
        s1_valid <= in_valid;
      end
      if (out_advance) begin
        out_valid <= s1_valid;
      end
    end
  end

  // Payload registers: no reset, load on advance only.
  always_ff @(posedge clk) begin
    if (in_valid && s1_advance) begin
      s1_item.dir   <= dir_mode;
      s1_item.pixel <= pixel_in;
    end
    if (s1_valid && out_advance) begin
      pixel_out <= result_next;
    end
  end

  // An accepted transaction lands in the input register.
  a_in_capture: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> s1_valid)
    else $error("accepted pixel did not enter the input register");

  // A pixel moving forward shows up as a result carrying its conversion.
  a_out_data: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_advance |=> out_valid && pixel_out == $past(result_next))
    else $error("result register does not hold the converted pixel");

  // A full pipeline behind a stalled output must stop taking input.
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready && s1_valid |-> !in_ready)
    else $error("input accepted while both stages are full and stalled");

  // A config write takes effect on the next cycle.
  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> dir_mode == $past(direction))
    else $error("direction register not updated by config write");

endmodule

// File: tb/sv/packed_float_rgbe_convert_test.sv
// Self-checking testbench for the packed-float / RGBE pixel converter.
`timescale 1ns / 1ps

module packed_float_rgbe_convert_test;
  import pfrc_pkg::*;

  // Give up well past the slowest legal run (gaps, stalls and latency).
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned PHASE_PIXELS = 150;
  localparam int unsigned DRAIN_CYCLES = 8;

  // One pending entry: a pixel transaction or a direction write.
  typedef struct {
    bit          is_cfg;
    logic [31:0] word;
  } pixel_job_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        direction = DIR_TO_RGBE;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] pixel_in = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] pixel_out;

  pixel_job_t  pixel_jobs[$];
  logic [31:0] expected_pixels[$];
  logic        dir_shadow = DIR_TO_RGBE;

  // Handshakes seen at the last rising edge, read by the falling-edge drivers.
  bit in_taken = 1'b0;
  bit cfg_taken = 1'b0;
  bit out_taken = 1'b0;

  int unsigned send_gap = 0;
  int unsigned hold_out = 0;
  int unsigned calm_in = 0;
  int unsigned calm_out = 0;
  int unsigned cycles = 0;
  int unsigned mismatches = 0;
  int unsigned results_checked = 0;
  int unsigned pixel_total = 0;

  packed_float_rgbe_convert u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .direction (direction),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .pixel_in  (pixel_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pixel_out (pixel_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Shift one widened channel (5-bit exponent, 10-bit mantissa) down to the
  // shared exponent and keep the low byte.
  function automatic logic [7:0] mant_to_byte(logic [14:0] chan, logic [4:0] shared_exp);
    int          shift;
    logic [10:0] mant;
    logic [10:0] shifted;
    mant = {1'b1, chan[9:0]};
    // A channel more than 3 above the shared exponent gets no shift at all; only exponent 31 can lie above it.
    shift = (int'(shared_exp) + 3 >= int'(chan[14:10])) ?
            int'(shared_exp) + 3 - int'(chan[14:10]) : 0;
    if (shift >= 11) return 8'h00;
    shifted = mant >> shift;
    return shifted[7:0];
  endfunction

  function automatic logic [31:0] pack_to_rgbe(logic [31:0] px);
    logic [14:0] chans[3];
    logic [4:0]  shared_exp;
    // Widen: field bits on top, low mantissa end refilled from the field top.
    chans[0] = {px[10:0], px[10:7]};
    chans[1] = {px[21:11], px[21:18]};
    chans[2] = {px[31:22], px[31:27]};
    shared_exp = '0;
    // Exponent 31 never takes part in the shared exponent.
    for (int i = 0; i < 3; i++)
      if (chans[i][14:10] != EXP_INF && chans[i][14:10] > shared_exp)
        shared_exp = chans[i][14:10];
    if (shared_exp == 0) return NO_EXP_WORD;
    return {8'(int'(shared_exp) + E_BIAS), mant_to_byte(chans[2], shared_exp),
            mant_to_byte(chans[1], shared_exp), mant_to_byte(chans[0], shared_exp)};
  endfunction

  // Normalize one RGBE byte into a 5-bit exponent and 10-bit mantissa.
  function automatic logic [14:0] byte_to_half(logic [7:0] val, logic [7:0] ebyte);
    int          expo;
    logic [10:0] frac;
    expo = int'(ebyte) - E_BIAS;
    frac = {val, 3'b000};
    if (frac == 0) return 15'd0;
    while (!frac[10]) begin
      frac = frac << 1;
      expo--;
    end
    if (expo < 1) return 15'd0;
    if (expo > int'(EXP_MAX)) return {EXP_MAX, MAN_MASK};
    return {expo[4:0], frac[9:0]};
  endfunction

  function automatic logic [31:0] rgbe_to_pack(logic [31:0] px);
    logic [14:0] cr, cg, cb;
    cr = byte_to_half(px[7:0], px[31:24]);
    cg = byte_to_half(px[15:8], px[31:24]);
    cb = byte_to_half(px[23:16], px[31:24]);
    // Truncate into the 11/11/10 fields.
    return {cb[14:5], cg[14:4], cr[14:4]};
  endfunction

  function automatic logic [31:0] convert_pixel(logic [31:0] px, logic dir);
    return (dir == DIR_TO_PACKED) ? rgbe_to_pack(px) : pack_to_rgbe(px);
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  function automatic logic [31:0] pack_fields(logic [10:0] r, logic [10:0] g, logic [9:0] b);
    return {b, g, r};
  endfunction

  // Draw a random wait; now and then start a run with no waits.
  function automatic int unsigned pick_wait(inout int unsigned calm);
    if (calm != 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) calm = $urandom_range(10, 60);
    return $urandom_range(0, 15);
  endfunction

  // Exponent near the shared one so shifts land inside the byte; sometimes
  // a zero or an infinite exponent.
  function automatic logic [4:0] near_exp(int top);
    int lo;
    unique case ($urandom_range(0, 9))
      0: return 5'd0;
      1: return EXP_INF;
      default: begin
        lo = top - 12;
        if (lo < 0) lo = 0;
        return 5'($urandom_range(lo, top));
      end
    endcase
  endfunction

  function automatic logic [31:0] random_packed();
    int top;
    if ($urandom_range(0, 3) == 0) return $urandom;
    top = $urandom_range(1, 30);
    return pack_fields({near_exp(top), 6'($urandom)}, {near_exp(top), 6'($urandom)},
                       {near_exp(top), 5'($urandom)});
  endfunction

  function automatic logic [7:0] random_byte();
    return ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom);
  endfunction

  function automatic logic [31:0] random_rgbe();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return {8'($urandom_range(96, 150)), random_byte(), random_byte(), random_byte()};
  endfunction

  function automatic void add_pixel(logic [31:0] word);
    pixel_jobs.push_back('{is_cfg: 1'b0, word: word});
    pixel_total++;
  endfunction

  function automatic void add_dir_write(logic dir);
    pixel_jobs.push_back('{is_cfg: 1'b1, word: {31'd0, dir}});
  endfunction

  // ---------------------------------------------------------------------
  // Driver: pixel and direction transactions, changed on the falling edge
  // ---------------------------------------------------------------------
  always @(negedge clk) begin : drive_inputs
    logic        nxt_in_valid;
    logic        nxt_cfg_valid;
    logic [31:0] nxt_pixel;
    logic        nxt_dir;
    pixel_job_t  job;
    // Hold any transaction that has not been taken yet.
    nxt_in_valid = in_valid && !in_taken;
    nxt_cfg_valid = cfg_valid && !cfg_taken;
    nxt_pixel = pixel_in;
    nxt_dir = direction;
    if (!rst && !nxt_in_valid && !nxt_cfg_valid) begin
      if (send_gap != 0) begin
        send_gap--;
      end else if (pixel_jobs.size() != 0) begin
        job = pixel_jobs[0];
        if (!job.is_cfg) begin
          nxt_in_valid = 1'b1;
          nxt_pixel = job.word;
          void'(pixel_jobs.pop_front());
          send_gap = pick_wait(calm_in);
        end else if (expected_pixels.size() == 0) begin
          // Write the direction only with nothing in flight.
          nxt_cfg_valid = 1'b1;
          nxt_dir = job.word[0];
          void'(pixel_jobs.pop_front());
        end
      end
    end
    in_valid <= nxt_in_valid;
    pixel_in <= nxt_pixel;
    cfg_valid <= nxt_cfg_valid;
    direction <= nxt_dir;
  end

  // Stall the result side for a drawn number of cycles after each transaction.
  always @(negedge clk) begin : throttle_results
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_taken) hold_out = pick_wait(calm_out);
      if (hold_out != 0) begin
        hold_out--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: record handshakes on the rising edge, predict and compare
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    logic [31:0] want;
    in_taken = !rst && in_valid && in_ready;
    cfg_taken = !rst && cfg_valid && cfg_ready;
    out_taken = !rst && out_valid && out_ready;
    if (rst) begin
      dir_shadow = DIR_TO_RGBE;
    end else begin
      cycles++;
      if (cfg_taken) dir_shadow = direction;
      if (in_taken) expected_pixels.push_back(convert_pixel(pixel_in, dir_shadow));
      if (out_taken) begin
        if (expected_pixels.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected pixel_out %h", $time, pixel_out);
        end else begin
          want = expected_pixels.pop_front();
          results_checked++;
          if (pixel_out !== want) begin
            mismatches++;
            $display("%0t: pixel_out expected %h actual %h", $time, want, pixel_out);
          end
        end
      end
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Sequence: reset, directed pixels in both directions, random phases
  // ---------------------------------------------------------------------
  initial begin
    // Packed float to RGBE, directed corners.
    add_dir_write(DIR_TO_RGBE);
    add_pixel(32'h0000_0000);                          // no usable exponent
    add_pixel(32'hFFFF_FFFF);                          // every exponent infinite
    add_pixel(pack_fields(11'h7C0, 11'h000, 10'h000)); // only an infinite channel
    add_pixel(pack_fields(11'h001, 11'h000, 10'h000)); // denormal only
    add_pixel(pack_fields(11'h7FF, 11'h3C0, 10'h1E0)); // infinite channel beside normal
    add_pixel(pack_fields(11'h7BF, 11'h7BF, 10'h3DF)); // largest finite everywhere
    add_pixel(pack_fields(11'h780, 11'h040, 10'h000)); // large exponent gap
    add_pixel(pack_fields(11'h040, 11'h000, 10'h000)); // smallest normal exponent
    add_pixel(pack_fields(11'h500, 11'h300, 10'h140)); // shifts near the byte edge
    add_pixel(32'h5555_5555);
    add_pixel(32'hAAAA_AAAA);
    // RGBE to packed float, directed corners.
    add_dir_write(DIR_TO_PACKED);
    add_pixel(32'h0000_0000);                          // zero bytes
    add_pixel(32'hFFFF_FFFF);                          // saturate
    add_pixel(32'h00FF_FFFF);                          // exponent below one
    add_pixel(32'h7001_0203);                          // normalizes below one
    add_pixel(32'h7101_0101);
    add_pixel(32'h7F01_0000);
    add_pixel(32'h80FF_8001);
    add_pixel(32'h8E80_8080);                          // exponent exactly 30
    add_pixel(32'h8F80_8080);                          // one past 30
    add_pixel(32'hA5A5_A5A5);
    add_pixel(32'h5A5A_5A5A);

    // Random phases, alternating direction.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      add_dir_write((p % 2 == 0) ? DIR_TO_RGBE : DIR_TO_PACKED);
      for (int n = 0; n < PHASE_PIXELS; n++)
        add_pixel((p % 2 == 0) ? random_packed() : random_rgbe());
    end

    // Hold reset, then release it on a falling edge.
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Drain: wait for every result, then keep watching for stray output.
    while (results_checked < pixel_total) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
